// File: rtl/pmfb_pkg.sv
package pmfb_pkg;

  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned PROBE_REGS    = 4;
  localparam int unsigned CHARS_PER_REG = 8;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned POS_W         = 17;
  localparam int unsigned TYPE_W        = 2;
  localparam int unsigned PROBE_BITS    = PROBE_REGS * CFG_DATA_W;

  localparam int unsigned DEF_MAX_PROBE     = 32;
  localparam int unsigned DEF_FLIP_POSITION = 12;
  localparam int unsigned DEF_MAX_TEXT      = 65536;

  localparam logic [LEN_W-1:0] LEN_RESET = 6'd25;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHARS_LOW      = 3'd0,
    CFG_CHARS_MID_LOW  = 3'd1,
    CFG_CHARS_MID_HIGH = 3'd2,
    CFG_CHARS_HIGH     = 3'd3,
    CFG_LENGTH         = 3'd4
  } cfg_idx_e;

  typedef enum logic [TYPE_W-1:0] {
    MATCH_NONE    = 2'd0,
    MATCH_PERFECT = 2'd1,
    MATCH_FLIPPED = 2'd2,
    MATCH_SHORT   = 2'd3
  } match_type_e;

  function automatic logic [CHAR_W-1:0] complement_base(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    case (c)
      "A":     r = "T";
      "T":     r = "A";
      "C":     r = "G";
      "G":     r = "C";
      "a":     r = "t";
      "t":     r = "a";
      "c":     r = "g";
      "g":     r = "c";
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/pmfb_align.sv
// Right-aligns the probe to the end of the character window, one lane per
// window slot, with the flipped variant and the active mask. Registered.
module pmfb_align import pmfb_pkg::*; #(
  parameter int unsigned MAX_PROBE     = DEF_MAX_PROBE,
  parameter int unsigned FLIP_POSITION = DEF_FLIP_POSITION
) (
  input  logic                                clk_i,
  input  logic [PROBE_BITS-1:0]               probe_chars_i,
  input  logic [LEN_W-1:0]                    probe_len_i,
  output logic [MAX_PROBE-1:0][CHAR_W-1:0]    lane_p_o,
  output logic [MAX_PROBE-1:0][CHAR_W-1:0]    lane_q_o,
  output logic [MAX_PROBE-1:0]                lane_act_o
);

  logic [LEN_W-1:0]                  off;
  logic [MAX_PROBE-1:0][LEN_W-1:0]   idx;
  logic [MAX_PROBE-1:0][CHAR_W-1:0]  ch;
  logic [MAX_PROBE-1:0][CHAR_W-1:0]  lane_p_d, lane_q_d, lane_p_q, lane_q_q;
  logic [MAX_PROBE-1:0]              lane_act_d, lane_act_q;

  assign off = LEN_W'(MAX_PROBE) - probe_len_i;

  always_comb begin
    for (int j = 0; j < MAX_PROBE; j++) begin
      idx[j]        = LEN_W'(j) - off;
      ch[j]         = probe_chars_i[{idx[j][LEN_W-2:0], 3'b000} +: CHAR_W];
      lane_act_d[j] = (LEN_W'(j) >= off);
      lane_p_d[j]   = ch[j];
      lane_q_d[j]   = (idx[j] == LEN_W'(FLIP_POSITION)) ? complement_base(ch[j]) : ch[j];
    end
  end

  always_ff @(posedge clk_i) begin
    lane_p_q   <= lane_p_d;
    lane_q_q   <= lane_q_d;
    lane_act_q <= lane_act_d;
  end

  assign lane_p_o   = lane_p_q;
  assign lane_q_o   = lane_q_q;
  assign lane_act_o = lane_act_q;

endmodule

// File: rtl/probe_match_with_flipped_base.sv
// Streaming probe search: takes one sequence character per cycle on the input
// stream and compares every window against the configured probe (up to
// MAX_PROBE characters) and against the probe with the base at FLIP_POSITION
// complemented, using one comparator lane per window slot. A beat with tlast
// produces one result: perfect match (first 1-based start) if any, otherwise
// probe-too-short when the length does not reach past the flip position,
// otherwise the first flipped-base match, otherwise none. Throughput is one
// character per cycle; a result is written to the output register when its last
// beat leaves the input register, and input stalls only when a finished result is
// still waiting while another last beat needs the output register. Characters past
// MAX_TEXT are not searched; lengths above MAX_PROBE clamp. The user must write probe
// registers via the config channel while the stream is idle; the block does not enforce it.
module probe_match_with_flipped_base import pmfb_pkg::*; #(
  parameter int unsigned MAX_PROBE     = DEF_MAX_PROBE,
  parameter int unsigned FLIP_POSITION = DEF_FLIP_POSITION,
  parameter int unsigned MAX_TEXT      = DEF_MAX_TEXT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] text_char
  input  logic                  s_axis_tlast,   // last_char
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,   // [16:0] match_position, [22:17] match_length
  output logic [1:0]            m_axis_tuser    // [1:0] match_type
);

  localparam int unsigned CNT_W = $clog2(MAX_TEXT + 1);
  localparam int unsigned PW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // config
  logic [PROBE_REGS-1:0][CFG_DATA_W-1:0] probe_q;
  logic [LEN_W-1:0]                      probe_length_q;
  logic [LEN_W-1:0]                      len;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q        <= '0;
      probe_length_q <= LEN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CHARS_LOW:      probe_q[0]     <= cfg_data_i;
        CFG_CHARS_MID_LOW:  probe_q[1]     <= cfg_data_i;
        CFG_CHARS_MID_HIGH: probe_q[2]     <= cfg_data_i;
        CFG_CHARS_HIGH:     probe_q[3]     <= cfg_data_i;
        CFG_LENGTH:         probe_length_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign len = (probe_length_q > LEN_W'(MAX_PROBE)) ? LEN_W'(MAX_PROBE) : probe_length_q;

  logic [MAX_PROBE-1:0][CHAR_W-1:0] lane_p, lane_q;
  logic [MAX_PROBE-1:0]             lane_act;

  pmfb_align #(
    .MAX_PROBE     (MAX_PROBE),
    .FLIP_POSITION (FLIP_POSITION)
  ) u_align (
    .clk_i         (clk_i),
    .probe_chars_i (probe_q),
    .probe_len_i   (len),
    .lane_p_o      (lane_p),
    .lane_q_o      (lane_q),
    .lane_act_o    (lane_act)
  );

  // input register
  logic              s1_valid_q;
  logic [CHAR_W-1:0] s1_char_q;
  logic              s1_last_q;
  logic              s1_adv;
  logic              out_valid_q;

  assign s1_adv        = s1_valid_q && (!s1_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_char_q <= s_axis_tdata;
      s1_last_q <= s_axis_tlast;
    end
  end

  // search state
  logic [MAX_PROBE-2:0][CHAR_W-1:0] win_q;
  logic [MAX_PROBE-1:0][CHAR_W-1:0] seq;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc, start;
  logic             pf_q, pf_d, ff_q, ff_d;
  logic [CNT_W-1:0] ps_q, ps_d, fs_q, fs_d;
  logic             in_range, pm, mm, long_enough;

  assign in_range = (cnt_q < CNT_W'(MAX_TEXT));
  assign cnt_inc  = cnt_q + 1'b1;
  assign start    = cnt_inc - CNT_W'(len) + 1'b1;
  assign long_enough = (cnt_inc >= CNT_W'(len));

  always_comb begin
    for (int j = 0; j < MAX_PROBE - 1; j++) begin
      seq[j] = win_q[j];
    end
    seq[MAX_PROBE-1] = s1_char_q;
    pm = 1'b1;
    mm = (len > LEN_W'(FLIP_POSITION));
    for (int j = 0; j < MAX_PROBE; j++) begin
      if (lane_act[j] && (seq[j] != lane_p[j])) pm = 1'b0;
      if (lane_act[j] && (seq[j] != lane_q[j])) mm = 1'b0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    pf_d  = pf_q;
    ps_d  = ps_q;
    ff_d  = ff_q;
    fs_d  = fs_q;
    if (in_range) begin
      cnt_d = cnt_inc;
      if (len == '0) begin
        if (!pf_q) begin
          pf_d = 1'b1;
          ps_d = CNT_W'(1);
        end
      end else if (long_enough) begin
        if (pm && !pf_q) begin
          pf_d = 1'b1;
          ps_d = start;
        end
        if (mm && !ff_q) begin
          ff_d = 1'b1;
          fs_d = start;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pf_q  <= 1'b0;
      ff_q  <= 1'b0;
      ps_q  <= '0;
      fs_q  <= '0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        cnt_q <= '0;
        pf_q  <= 1'b0;
        ff_q  <= 1'b0;
        ps_q  <= '0;
        fs_q  <= '0;
      end else begin
        cnt_q <= cnt_d;
        pf_q  <= pf_d;
        ff_q  <= ff_d;
        ps_q  <= ps_d;
        fs_q  <= fs_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_range) begin
      for (int j = 0; j < MAX_PROBE - 1; j++) begin
        win_q[j] <= seq[j+1];
      end
    end
  end

  // result register
  match_type_e      res_type;
  logic [PW-1:0]    res_pos;
  logic [LEN_W-1:0] res_len;
  match_type_e      out_type_q;
  logic [POS_W-1:0] out_pos_q;
  logic [LEN_W-1:0] out_len_q;

  always_comb begin
    if (pf_d) begin
      res_type = MATCH_PERFECT;
      res_pos  = PW'(ps_d);
      res_len  = len;
    end else if (len <= LEN_W'(FLIP_POSITION)) begin
      res_type = MATCH_SHORT;
      res_pos  = '0;
      res_len  = '0;
    end else if (ff_d) begin
      res_type = MATCH_FLIPPED;
      res_pos  = PW'(fs_d);
      res_len  = len;
    end else begin
      res_type = MATCH_NONE;
      res_pos  = '0;
      res_len  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_type_q <= res_type;
      out_pos_q  <= res_pos[POS_W-1:0];
      out_len_q  <= res_len;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_type_q;
  assign m_axis_tdata  = {1'b0, out_len_q, out_pos_q};

endmodule
